// ----- sv/i2cwrs_pkg.sv -----
// Shared constants, codes and types of the I2C write-then-read sequencer.
`default_nettype none
package i2cwrs_pkg;

   localparam int TX_DEPTH = 16;
   localparam int TX_AW    = $clog2(TX_DEPTH);
   localparam int TX_CW    = $clog2(TX_DEPTH + 1);
   localparam int RX_MAX   = 255;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SUBMIT = 2'd1,
      CMD_DONE   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_SEND    = 3'd2,
      ACT_RESTART = 3'd3,
      ACT_RX_EN   = 3'd4,
      ACT_ACK     = 3'd5,
      ACT_NACK    = 3'd6,
      ACT_STOP    = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_ADDRESS    = 3'd1,
      PH_CHECK_ACK  = 3'd2,
      PH_WRITE      = 3'd3,
      PH_READ_START = 3'd4,
      PH_READ       = 3'd5,
      PH_STOP       = 3'd6
   } phase_type;

   typedef struct packed {
      action_type action;
      logic [7:0] addr_byte;
      logic       use_mem;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       done;
      logic       ok;
      logic       accepted;
   } result_type;

   typedef struct packed {
      logic             we;
      logic [TX_AW-1:0] waddr;
      logic [7:0]       wdata;
      logic             re;
      logic [TX_AW-1:0] raddr;
   } mem_req_type;

endpackage
`default_nettype wire

// ----- sv/i2cwrs_seq.sv -----
// Transaction sequencer: phase machine, counters and tx store access requests.
`default_nettype none
module i2cwrs_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire i2cwrs_pkg::cmd_type  cmd,
   input  wire logic [7:0]           data_byte,
   input  wire logic [7:0]           target_address,
   input  wire logic [4:0]           write_count,
   input  wire logic [7:0]           read_count,
   input  wire logic                 ack_seen,
   output i2cwrs_pkg::result_type    result,
   output i2cwrs_pkg::mem_req_type   mem_req
);

   localparam logic [i2cwrs_pkg::TX_CW-1:0] TxDepthC =
      i2cwrs_pkg::TX_CW'(i2cwrs_pkg::TX_DEPTH);
   localparam logic [7:0] RxMaxC = 8'(i2cwrs_pkg::RX_MAX);

   i2cwrs_pkg::phase_type phase_ff, phase_in;
   logic                            reading_ff, reading_in;
   logic                            pending_ff, pending_in;
   logic [i2cwrs_pkg::TX_CW-1:0]    tx_index_ff, tx_index_in;
   logic [i2cwrs_pkg::TX_CW-1:0]    tx_total_ff, tx_total_in;
   logic [7:0]                      rx_index_ff, rx_index_in;
   logic [7:0]                      rx_total_ff, rx_total_in;
   logic [7:0]                      dev_addr_ff, dev_addr_in;
   logic                            ok_ff, ok_in;

   logic       busy;
   logic       can_load;
   logic       write_more;
   logic [8:0] rx_next;
   logic       rx_more;

   assign busy       = (phase_ff != i2cwrs_pkg::PH_IDLE) || pending_ff;
   assign can_load   = !busy && (tx_index_ff < TxDepthC);
   assign write_more = tx_index_ff < tx_total_ff;
   assign rx_next    = {1'b0, rx_index_ff} + 9'd1;
   assign rx_more    = rx_next < {1'b0, rx_total_ff};

   always_comb begin
      phase_in    = phase_ff;
      reading_in  = reading_ff;
      pending_in  = pending_ff;
      tx_index_in = tx_index_ff;
      tx_total_in = tx_total_ff;
      rx_index_in = rx_index_ff;
      rx_total_in = rx_total_ff;
      dev_addr_in = dev_addr_ff;
      ok_in       = ok_ff;
      unique case (cmd)
         i2cwrs_pkg::CMD_LOAD: begin
            if (can_load) begin
               tx_index_in = tx_index_ff + 1'b1;
            end
         end
         i2cwrs_pkg::CMD_SUBMIT: begin
            if (!busy) begin
               dev_addr_in = target_address;
               tx_total_in = (write_count > TxDepthC) ? TxDepthC : write_count;
               rx_total_in = (read_count > RxMaxC) ? RxMaxC : read_count;
               tx_index_in = '0;
               rx_index_in = '0;
               ok_in       = 1'b0;
               pending_in  = 1'b1;
               reading_in  = 1'b0;
               phase_in    = i2cwrs_pkg::PH_ADDRESS;
            end
         end
         i2cwrs_pkg::CMD_DONE: begin
            unique case (phase_ff)
               i2cwrs_pkg::PH_ADDRESS: begin
                  phase_in = i2cwrs_pkg::PH_CHECK_ACK;
               end
               i2cwrs_pkg::PH_CHECK_ACK, i2cwrs_pkg::PH_WRITE: begin
                  if (phase_ff == i2cwrs_pkg::PH_CHECK_ACK && !ack_seen) begin
                     ok_in       = 1'b0;
                     pending_in  = 1'b0;
                     phase_in    = i2cwrs_pkg::PH_IDLE;
                     tx_index_in = '0;
                  end else if (phase_ff == i2cwrs_pkg::PH_CHECK_ACK && reading_ff) begin
                     phase_in = i2cwrs_pkg::PH_READ;
                  end else if (write_more) begin
                     tx_index_in = tx_index_ff + 1'b1;
                     phase_in    = i2cwrs_pkg::PH_WRITE;
                  end else if (rx_total_ff != 8'd0) begin
                     reading_in = 1'b1;
                     phase_in   = i2cwrs_pkg::PH_ADDRESS;
                  end else begin
                     ok_in       = 1'b1;
                     pending_in  = 1'b0;
                     phase_in    = i2cwrs_pkg::PH_IDLE;
                     tx_index_in = '0;
                  end
               end
               i2cwrs_pkg::PH_READ_START: begin
                  phase_in = i2cwrs_pkg::PH_READ;
               end
               i2cwrs_pkg::PH_READ: begin
                  rx_index_in = rx_next[7:0];
                  if (rx_more) begin
                     phase_in = i2cwrs_pkg::PH_READ_START;
                  end else begin
                     ok_in    = 1'b1;
                     phase_in = i2cwrs_pkg::PH_STOP;
                  end
               end
               i2cwrs_pkg::PH_STOP: begin
                  pending_in  = 1'b0;
                  phase_in    = i2cwrs_pkg::PH_IDLE;
                  tx_index_in = '0;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result  = '0;
      mem_req = '0;
      mem_req.waddr = tx_index_ff[i2cwrs_pkg::TX_AW-1:0];
      mem_req.raddr = tx_index_ff[i2cwrs_pkg::TX_AW-1:0];
      mem_req.wdata = data_byte;
      unique case (cmd)
         i2cwrs_pkg::CMD_LOAD: begin
            if (can_load) begin
               result.accepted = 1'b1;
               mem_req.we      = item_valid;
            end
         end
         i2cwrs_pkg::CMD_SUBMIT: begin
            if (!busy) begin
               result.accepted = 1'b1;
               result.action   = i2cwrs_pkg::ACT_START;
            end
         end
         i2cwrs_pkg::CMD_DONE: begin
            unique case (phase_ff)
               i2cwrs_pkg::PH_ADDRESS: begin
                  result.action    = i2cwrs_pkg::ACT_SEND;
                  result.addr_byte = reading_ff ? dev_addr_ff + 8'd1 : dev_addr_ff;
               end
               i2cwrs_pkg::PH_CHECK_ACK, i2cwrs_pkg::PH_WRITE: begin
                  if (phase_ff == i2cwrs_pkg::PH_CHECK_ACK && !ack_seen) begin
                     result.action = i2cwrs_pkg::ACT_STOP;
                     result.done   = 1'b1;
                  end else if (phase_ff == i2cwrs_pkg::PH_CHECK_ACK && reading_ff) begin
                     result.action = i2cwrs_pkg::ACT_RX_EN;
                  end else if (write_more) begin
                     result.action  = i2cwrs_pkg::ACT_SEND;
                     result.use_mem = 1'b1;
                     mem_req.re     = item_valid;
                  end else if (rx_total_ff != 8'd0) begin
                     result.action = i2cwrs_pkg::ACT_RESTART;
                  end else begin
                     result.action = i2cwrs_pkg::ACT_STOP;
                     result.done   = 1'b1;
                     result.ok     = 1'b1;
                  end
               end
               i2cwrs_pkg::PH_READ_START: begin
                  result.action = i2cwrs_pkg::ACT_RX_EN;
               end
               i2cwrs_pkg::PH_READ: begin
                  result.read_byte  = data_byte;
                  result.read_valid = 1'b1;
                  result.action     = rx_more ? i2cwrs_pkg::ACT_ACK : i2cwrs_pkg::ACT_NACK;
               end
               i2cwrs_pkg::PH_STOP: begin
                  result.action = i2cwrs_pkg::ACT_STOP;
                  result.done   = 1'b1;
                  result.ok     = ok_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= i2cwrs_pkg::PH_IDLE;
         reading_ff  <= 1'b0;
         pending_ff  <= 1'b0;
         tx_index_ff <= '0;
         tx_total_ff <= '0;
         rx_index_ff <= '0;
         rx_total_ff <= '0;
         dev_addr_ff <= '0;
         ok_ff       <= 1'b0;
      end else if (item_valid) begin
         phase_ff    <= phase_in;
         reading_ff  <= reading_in;
         pending_ff  <= pending_in;
         tx_index_ff <= tx_index_in;
         tx_total_ff <= tx_total_in;
         rx_index_ff <= rx_index_in;
         rx_total_ff <= rx_total_in;
         dev_addr_ff <= dev_addr_in;
         ok_ff       <= ok_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/i2c_master_write_read_sequencer.sv -----
// Top level of the I2C write-then-read sequencer with tx store and output register.
// Each beat on the request side is a load, a submit or a bus completion event, and each
// accepted beat yields exactly one response beat in the next cycle. One beat is taken per
// clock; the only wait comes from a full output register while the response side stalls.
// The tx bytes sit in a 16-entry store whose read data is registered alongside the
// response; loads happen only while idle and reads only while busy, so the two never meet.
`default_nettype none
module i2c_master_write_read_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // data_byte[7:0], target_address[15:8], write_count[20:16], read_count[28:21],
   // ack_seen[29], zero[31:30]
   input  wire logic [31:0] req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // bus_action[2:0], send_byte[10:3], read_byte[18:11], frame_done[19],
   // frame_ok[20], accepted[21], zero[23:22]
   output logic [23:0]      rsp_tdata,
   // read_valid[0]
   output logic [0:0]       rsp_tuser
);

   i2cwrs_pkg::result_type  seq_result;
   i2cwrs_pkg::mem_req_type mem_req;
   i2cwrs_pkg::result_type  out_ff;
   logic                    out_valid_ff;
   logic [7:0]              rdata_ff;
   logic [7:0]              tx_mem [i2cwrs_pkg::TX_DEPTH];
   logic                    req_accept;
   logic [7:0]              send_byte;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   i2cwrs_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (req_accept),
      .cmd            (i2cwrs_pkg::cmd_type'(req_tuser)),
      .data_byte      (req_tdata[7:0]),
      .target_address (req_tdata[15:8]),
      .write_count    (req_tdata[20:16]),
      .read_count     (req_tdata[28:21]),
      .ack_seen       (req_tdata[29]),
      .result         (seq_result),
      .mem_req        (mem_req)
   );

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         tx_mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= tx_mem[mem_req.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_tready) begin
         out_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         out_ff <= seq_result;
      end
   end

   assign send_byte  = out_ff.use_mem ? rdata_ff : out_ff.addr_byte;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.accepted, out_ff.ok, out_ff.done,
                        out_ff.read_byte, send_byte, out_ff.action};
   assign rsp_tuser  = out_ff.read_valid;

   a_ok_needs_done : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.ok |-> out_ff.done && out_ff.action == i2cwrs_pkg::ACT_STOP)
      else $error("frame_ok raised without a finishing stop");

   a_done_is_stop : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.done |-> out_ff.action == i2cwrs_pkg::ACT_STOP)
      else $error("frame_done raised on an action other than stop");

   a_read_ack : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.read_valid |->
         out_ff.action == i2cwrs_pkg::ACT_ACK || out_ff.action == i2cwrs_pkg::ACT_NACK)
      else $error("received byte returned without ack or nack");

   a_accept_action : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.accepted |->
         out_ff.action == i2cwrs_pkg::ACT_NONE || out_ff.action == i2cwrs_pkg::ACT_START)
      else $error("accepted flag on a completion response");

   a_no_mem_clash : assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && mem_req.re))
      else $error("tx store written and read in the same cycle");

endmodule
`default_nettype wire
